// ----- hw/rtl/rcsm_pkg.sv -----
// Package for the rotated canvas size and margins block.
// Holds the control struct, register indexes, angle constants and the
// elaboration-time quarter-wave sine used to build the lookup table.
`default_nettype none

package rcsm_pkg;

	localparam int ANGLE_W    = 9;    // rotation_degrees width
	localparam int DEG_W      = 7;    // folded angle 0..90
	localparam int TBL_DEPTH  = 91;   // quarter wave, 0..90 degrees
	localparam int CFG_DATA_W = 12;   // widest configuration register
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [ANGLE_W-1:0] FULL_TURN = 9'd360;
	localparam logic [ANGLE_W-1:0] HALF_TURN = 9'd180;
	localparam logic [DEG_W:0]     HALF_TURN_N = 8'd180;
	localparam logic [DEG_W-1:0]   QTR_TURN  = 7'd90;

	localparam longint unsigned DEG_TO_RAD_Q40 = 64'd19190098069;
	localparam longint unsigned Q30_HALF       = 64'd536870912;

	// Load enables for the stages behind the input register.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_out;
	} rcsm_ctl_t;

	function automatic longint unsigned mul_q30(input longint unsigned a,
		input longint unsigned b);
		return (a * b + Q30_HALF) >> 30;
	endfunction

	function automatic longint unsigned sub_sat(input longint unsigned a,
		input longint unsigned b);
		return (a >= b) ? a - b : 64'd0;
	endfunction

	// sin(r degrees) for r in 0..90, unsigned Q1.frac. Used only to build
	// constant tables at elaboration.
	function automatic longint unsigned quarter_sine(input int unsigned r,
		input int unsigned frac);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		x  = (64'(r) * DEG_TO_RAD_Q40 + 64'd512) >> 10;
		x2 = mul_q30(x, x);
		t  = mul_q30(x, x2);
		t  = (t + 64'd3) / 64'd6;
		s  = sub_sat(x, t);
		t  = mul_q30(t, x2);
		t  = (t + 64'd10) / 64'd20;
		s  = s + t;
		t  = mul_q30(t, x2);
		t  = (t + 64'd21) / 64'd42;
		s  = sub_sat(s, t);
		t  = mul_q30(t, x2);
		t  = (t + 64'd36) / 64'd72;
		s  = s + t;
		t  = mul_q30(t, x2);
		t  = (t + 64'd55) / 64'd110;
		s  = sub_sat(s, t);
		t  = mul_q30(t, x2);
		t  = (t + 64'd78) / 64'd156;
		s  = s + t;
		t  = mul_q30(t, x2);
		t  = (t + 64'd105) / 64'd210;
		s  = sub_sat(s, t);
		return ((s >> (29 - frac)) + 64'd1) >> 1;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rcsm_trig.sv -----
// Angle folding and sine/cosine lookup stage.
// Reduces the registered angle to 0..90 and registers |sin| and |cos|.
// Depends on rcsm_pkg.
`default_nettype none

module rcsm_trig #(
	parameter int FRAC_BITS = 16
) (
	input  wire                               clk,
	input  wire  rcsm_pkg::rcsm_ctl_t         ctl,
	input  wire  [rcsm_pkg::ANGLE_W-1:0]      angle_s1,
	output logic [FRAC_BITS:0]                sin_s2,
	output logic [FRAC_BITS:0]                cos_s2
);
	import rcsm_pkg::*;

	logic [FRAC_BITS:0] sine_tbl [0:TBL_DEPTH-1];
	logic [ANGLE_W-1:0] mod_angle;
	logic [DEG_W:0]     half_angle;
	logic [DEG_W-1:0]   fold_angle;
	logic [DEG_W-1:0]   comp_angle;

	for (genvar i = 0; i < TBL_DEPTH; i++) begin : g_tbl
		localparam longint unsigned Entry = quarter_sine(i, FRAC_BITS);
		assign sine_tbl[i] = Entry[FRAC_BITS:0];
	end

	always_comb begin
		if (angle_s1 >= FULL_TURN) begin
			mod_angle = angle_s1 - FULL_TURN;
		end else if (angle_s1 >= HALF_TURN) begin
			mod_angle = angle_s1 - HALF_TURN;
		end else begin
			mod_angle = angle_s1;
		end
		half_angle = mod_angle[DEG_W:0];
		// fold the second quadrant back onto the first
		if (half_angle > {1'b0, QTR_TURN}) begin
			fold_angle = DEG_W'(HALF_TURN_N - half_angle);
		end else begin
			fold_angle = half_angle[DEG_W-1:0];
		end
		comp_angle = QTR_TURN - fold_angle;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			sin_s2 <= sine_tbl[fold_angle];
			cos_s2 <= sine_tbl[comp_angle];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rcsm_span.sv -----
// Projection products, rounding and margin stage.
// Registers the four dimension-by-trig products, then the rounded canvas
// size and margins. Depends on rcsm_pkg.
`default_nettype none

module rcsm_span #(
	parameter int DIM_BITS  = 12,
	parameter int FRAC_BITS = 16
) (
	input  wire                         clk,
	input  wire  rcsm_pkg::rcsm_ctl_t   ctl,
	input  wire  [DIM_BITS-1:0]         image_width,
	input  wire  [DIM_BITS-1:0]         image_height,
	input  wire  [FRAC_BITS:0]          sin_s2,
	input  wire  [FRAC_BITS:0]          cos_s2,
	output logic [DIM_BITS:0]           canvas_width_q,
	output logic [DIM_BITS:0]           canvas_height_q,
	output logic [DIM_BITS-1:0]         margin_vertical_q,
	output logic [DIM_BITS-1:0]         margin_horizontal_q
);
	import rcsm_pkg::*;

	localparam int ProdW = DIM_BITS + FRAC_BITS + 1;
	localparam int SumW  = ProdW + 1;
	localparam logic [SumW-1:0] RoundHalf = SumW'(1) << (FRAC_BITS - 1);

	logic [ProdW-1:0]    wc_s3, hs_s3, ws_s3, hc_s3;
	logic [SumW-1:0]     sum_w, sum_h;
	logic [DIM_BITS:0]   canvas_w, canvas_h;
	logic [DIM_BITS+1:0] excess_w, excess_h;

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			wc_s3 <= ProdW'(image_width * cos_s2);
			hs_s3 <= ProdW'(image_height * sin_s2);
			ws_s3 <= ProdW'(image_width * sin_s2);
			hc_s3 <= ProdW'(image_height * cos_s2);
		end
	end

	always_comb begin
		sum_w    = SumW'(wc_s3) + SumW'(hs_s3) + RoundHalf;
		sum_h    = SumW'(ws_s3) + SumW'(hc_s3) + RoundHalf;
		canvas_w = sum_w[FRAC_BITS+DIM_BITS:FRAC_BITS];
		canvas_h = sum_h[FRAC_BITS+DIM_BITS:FRAC_BITS];
		excess_w = (DIM_BITS+2)'(canvas_w) - (DIM_BITS+2)'(image_width) + 1'b1;
		excess_h = (DIM_BITS+2)'(canvas_h) - (DIM_BITS+2)'(image_height) + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			canvas_width_q  <= canvas_w;
			canvas_height_q <= canvas_h;
			// no margin on an axis where the canvas came out smaller
			margin_horizontal_q <= (canvas_w < (DIM_BITS+1)'(image_width)) ?
				'0 : excess_w[DIM_BITS:1];
			margin_vertical_q   <= (canvas_h < (DIM_BITS+1)'(image_height)) ?
				'0 : excess_h[DIM_BITS:1];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rotated_canvas_size_and_margins_core.sv -----
// Top level: canvas size and margins for an image rotated by whole degrees.
// Instantiates rcsm_trig and rcsm_span; uses rcsm_pkg.
//
//   channel  dir  handshake             payload
//   in       in   in_valid / in_ready   rotation_degrees
//   out      out  out_valid / out_ready canvas_width, canvas_height,
//                                       margin_vertical, margin_horizontal
//   cfg      in   cfg_wr_en             cfg_index, cfg_data
//
// One item per cycle sustained while out is not stalled; the accepting edge
// loads the input register, then the sine/cosine lookup, the products and
// the rounded result are registered in turn, the last together with out_valid.
// Reset clears all valid bits and sets both image dimensions to 1.
// A stall on out backs up stage by stage; in_ready drops only when every
// stage holds an item and the output is not taken.
`default_nettype none

module rotated_canvas_size_and_margins_core #(
	parameter int DIM_BITS  = 12,
	parameter int FRAC_BITS = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_wr_en,
	input  wire  [rcsm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [rcsm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [rcsm_pkg::ANGLE_W-1:0]         rotation_degrees,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [DIM_BITS:0]                    canvas_width,
	output logic [DIM_BITS:0]                    canvas_height,
	output logic [DIM_BITS-1:0]                  margin_vertical,
	output logic [DIM_BITS-1:0]                  margin_horizontal
);
	import rcsm_pkg::*;

	logic [DIM_BITS-1:0] image_width_q;
	logic [DIM_BITS-1:0] image_height_q;
	logic [ANGLE_W-1:0]  angle_s1;
	logic                v_s1, v_s2, v_s3, out_valid_q;
	logic [FRAC_BITS:0]  sin_s2, cos_s2;
	rcsm_ctl_t           ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_BITS'(1);
			image_height_q <= DIM_BITS'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= DIM_BITS'(cfg_data);
				REG_IMAGE_HEIGHT: image_height_q <= DIM_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its item moves on this cycle
	always_comb begin
		ctl.ld_out = !out_valid_q || out_ready;
		ctl.ld_s3  = !v_s3 || ctl.ld_out;
		ctl.ld_s2  = !v_s2 || ctl.ld_s3;
		in_ready   = !v_s1 || ctl.ld_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (ctl.ld_s2) v_s2 <= v_s1;
			if (ctl.ld_s3) v_s3 <= v_s2;
			if (ctl.ld_out) out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			angle_s1 <= rotation_degrees;
		end
	end

	rcsm_trig #(
		.FRAC_BITS(FRAC_BITS)
	) u_trig (
		.clk      (clk),
		.ctl      (ctl),
		.angle_s1 (angle_s1),
		.sin_s2   (sin_s2),
		.cos_s2   (cos_s2)
	);

	rcsm_span #(
		.DIM_BITS (DIM_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_span (
		.clk                 (clk),
		.ctl                 (ctl),
		.image_width         (image_width_q),
		.image_height        (image_height_q),
		.sin_s2              (sin_s2),
		.cos_s2              (cos_s2),
		.canvas_width_q      (canvas_width),
		.canvas_height_q     (canvas_height),
		.margin_vertical_q   (margin_vertical),
		.margin_horizontal_q (margin_horizontal)
	);

	assign out_valid = out_valid_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("in_ready low with empty input stage");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted item missing from input stage");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !in_ready |=> v_s1 && $stable(angle_s1))
		else $error("stalled item lost from input stage");

	a_margin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (DIM_BITS+2)'(margin_horizontal) <=
			(((DIM_BITS+2)'(canvas_width) + 1'b1) >> 1))
		else $error("horizontal margin exceeds half the canvas");

endmodule

`default_nettype wire
